[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros used by the request framer design file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising edge of the given clock, off while in reset.
`define AST_PROP_CLK(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);

// Check a property on clk, off while rst_n is low.
`define AST_PROP(lbl, prop, msg) \
  `AST_PROP_CLK(lbl, clk, rst_n, prop, msg)

`endif

[design/mbrtu_pkg.sv]
// ----------------------------------------------------------------------------
// mbrtu_pkg
// Types, constants and the CRC-16/Modbus byte update for the request framer.
// ----------------------------------------------------------------------------
package mbrtu_pkg;

  localparam int unsigned FRAME_LEN   = 8;
  localparam int unsigned PAYLOAD_LEN = 6;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned PAYLOAD_W   = PAYLOAD_LEN * BYTE_W;
  localparam int unsigned FRAME_W     = FRAME_LEN * BYTE_W;
  localparam int unsigned POS_W       = $clog2(FRAME_LEN);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef struct packed {
    logic [7:0]  slave_addr;
    logic [7:0]  func_code;
    logic [15:0] reg_addr;
    logic [15:0] reg_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last_byte;
  } out_item_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

[design/modbus_rtu_request_framer_top.sv]
// ----------------------------------------------------------------------------
// modbus_rtu_request_framer_top
// Builds the 8-byte Modbus RTU request frame with CRC-16/Modbus.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive in_item and raise start; the item is taken at a
//   rising edge where start is high and busy is low.
//   Result channel: out_strobe marks one frame byte on out_item for exactly
//   one cycle: slave address, function code, register high, register low,
//   value high, value low, CRC low, CRC high. last_byte is set on CRC high.
//   The receiver takes every byte; it cannot hold the block off.
// Timing:
//   Six register stages fold one payload byte each into the CRC, then a
//   shift register sends the frame one byte a cycle. An item waits in its
//   stage while the one after it is full; the first byte of an item is on
//   the ports once the serialiser loads it. Each byte is taken at the edge
//   that ends its cycle. The byte serialiser sets the pace; frames leave
//   back to back with no gap while items wait. Items queue in the CRC stages,
//   and busy rises once they are all full and the serialiser cannot take one.
// Reset:
//   rst_n low on a rising edge empties every stage and the serialiser; no
//   strobe follows until a new item is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module modbus_rtu_request_framer_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  mbrtu_pkg::in_item_t  in_item,
  output logic                 out_strobe,
  output mbrtu_pkg::out_item_t out_item
);

  localparam int unsigned NSTG = mbrtu_pkg::PAYLOAD_LEN;
  localparam int unsigned PW   = mbrtu_pkg::PAYLOAD_W;
  localparam int unsigned BW   = mbrtu_pkg::BYTE_W;
  localparam int unsigned FW   = mbrtu_pkg::FRAME_W;
  localparam int unsigned CW   = mbrtu_pkg::POS_W;
  localparam logic [CW-1:0] LAST_POS = CW'(mbrtu_pkg::FRAME_LEN - 1);

  logic [NSTG-1:0] stg_v_r, stg_v_nxt;
  logic [PW-1:0]   stg_pay_r [NSTG];
  logic [PW-1:0]   stg_pay_nxt [NSTG];
  logic [15:0]     stg_crc_r [NSTG];
  logic [15:0]     stg_crc_nxt [NSTG];
  logic [NSTG-1:0] stg_free;

  logic            ser_act_r, ser_act_nxt;
  logic [CW-1:0]   ser_cnt_r, ser_cnt_nxt;
  logic [FW-1:0]   ser_frame_r, ser_frame_nxt;
  logic            ser_free;
  logic            accept;

  assign ser_free = !ser_act_r || (ser_cnt_r == LAST_POS);

  always_comb begin
    stg_free[NSTG-1] = !stg_v_r[NSTG-1] || ser_free;
    for (int i = NSTG - 2; i >= 0; i--) begin
      stg_free[i] = !stg_v_r[i] || stg_free[i+1];
    end
  end

  assign busy   = !stg_free[0];
  assign accept = start && stg_free[0];

  // advance each stage when the one after it can take its item, else hold
  always_comb begin
    for (int i = 0; i < NSTG; i++) begin
      stg_v_nxt[i]   = stg_v_r[i];
      stg_pay_nxt[i] = stg_pay_r[i];
      stg_crc_nxt[i] = stg_crc_r[i];
    end
    if (stg_free[0]) begin
      stg_v_nxt[0]   = start;
      stg_pay_nxt[0] = in_item;
      stg_crc_nxt[0] = mbrtu_pkg::crc_feed(mbrtu_pkg::CRC_INIT, in_item[PW-1 -: BW]);
    end
    for (int i = 1; i < NSTG; i++) begin
      if (stg_free[i]) begin
        stg_v_nxt[i]   = stg_v_r[i-1];
        stg_pay_nxt[i] = stg_pay_r[i-1];
        stg_crc_nxt[i] = mbrtu_pkg::crc_feed(stg_crc_r[i-1],
                                             stg_pay_r[i-1][PW-1-BW*i -: BW]);
      end
    end
  end

  always_comb begin
    ser_act_nxt   = ser_act_r;
    ser_cnt_nxt   = ser_cnt_r;
    ser_frame_nxt = ser_frame_r;
    if (ser_free) begin
      ser_act_nxt   = stg_v_r[NSTG-1];
      ser_cnt_nxt   = '0;
      ser_frame_nxt = {stg_pay_r[NSTG-1], stg_crc_r[NSTG-1][7:0],
                       stg_crc_r[NSTG-1][15:8]};
    end else begin
      ser_cnt_nxt   = ser_cnt_r + 1'b1;
      ser_frame_nxt = {ser_frame_r[FW-BW-1:0], {BW{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r   <= '0;
      ser_act_r <= 1'b0;
      ser_cnt_r <= '0;
    end else begin
      stg_v_r   <= stg_v_nxt;
      ser_act_r <= ser_act_nxt;
      ser_cnt_r <= ser_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NSTG; i++) begin
      stg_pay_r[i] <= stg_pay_nxt[i];
      stg_crc_r[i] <= stg_crc_nxt[i];
    end
    ser_frame_r <= ser_frame_nxt;
  end

  assign out_strobe         = ser_act_r;
  assign out_item.tx_byte   = ser_frame_r[FW-1 -: BW];
  assign out_item.last_byte = ser_act_r && (ser_cnt_r == LAST_POS);

  `AST_PROP(a_accept_lands, accept |=> stg_v_r[0], "accepted item not held in first stage")
  `AST_PROP(a_busy_full, busy |-> (stg_v_r == '1), "busy raised with a free stage")
  `AST_PROP(a_frame_unbroken, (out_strobe && !out_item.last_byte) |=> out_strobe,
            "frame interrupted before its last byte")
  `AST_PROP(a_next_frame_start, (out_strobe && out_item.last_byte) |=>
            (!out_strobe || ser_cnt_r == '0), "frame after last byte does not start at byte zero")

endmodule

[bench/modbus_rtu_request_framer_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// modbus_rtu_request_framer_top_tb
// Self-checking bench for the Modbus RTU request framer.
// Requests go in through start/busy, first from a short table of corner
// cases and then at random, with random gaps and gap-free bursts. Each
// accepted request is turned into its eight frame bytes with CRC-16/Modbus
// worked out bit by bit, or typed in for two table rows. Every strobed
// byte is checked in order against those bytes and the end-of-frame marker.
// ----------------------------------------------------------------------------
module modbus_rtu_request_framer_top_tb;

  localparam int unsigned RANDOM_REQUESTS = 270;
  localparam int unsigned DRAIN_CYCLES    = 20;
  localparam logic [7:0]  FC_READ_HOLDING = 8'h03;
  localparam logic [7:0]  FC_WRITE_SINGLE = 8'h06;

  typedef struct packed {
    mbrtu_pkg::in_item_t req;
    logic                crc_given;
    logic [15:0]         crc;
  } request_row_t;

  localparam int unsigned NUM_ROWS = 14;
  localparam request_row_t REQUEST_TABLE [NUM_ROWS] = '{
    {8'h01, FC_READ_HOLDING, 16'h0000, 16'h000A, 1'b1, 16'hCDC5},
    {8'h01, FC_READ_HOLDING, 16'h0000, 16'h0001, 1'b1, 16'h0A84},
    {8'h00, 8'h00,           16'h0000, 16'h0000, 1'b0, 16'h0000},
    {8'hFF, 8'hFF,           16'hFFFF, 16'hFFFF, 1'b0, 16'h0000},
    {8'hFF, 8'h00,           16'h0000, 16'h0000, 1'b0, 16'h0000},
    {8'h00, 8'hFF,           16'h0000, 16'h0000, 1'b0, 16'h0000},
    {8'h00, 8'h00,           16'hFFFF, 16'h0000, 1'b0, 16'h0000},
    {8'h00, 8'h00,           16'h0000, 16'hFFFF, 1'b0, 16'h0000},
    {8'h11, FC_WRITE_SINGLE, 16'h0001, 16'h8000, 1'b0, 16'h0000},
    {8'hF7, FC_WRITE_SINGLE, 16'h2000, 16'hFFFE, 1'b0, 16'h0000},
    {8'hAA, 8'h55,           16'hAA55, 16'h55AA, 1'b0, 16'h0000},
    {8'h55, 8'hAA,           16'h55AA, 16'hAA55, 1'b0, 16'h0000},
    {8'h80, 8'h7F,           16'h8001, 16'h7FFF, 1'b0, 16'h0000},
    {8'h01, 8'h10,           16'h0100, 16'h0000, 1'b0, 16'h0000}
  };

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  mbrtu_pkg::in_item_t  in_item;
  logic                 out_strobe;
  mbrtu_pkg::out_item_t out_item;

  mbrtu_pkg::out_item_t pending_bytes[$];
  int                   mismatches;

  modbus_rtu_request_framer_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #1ms;
    $display("modbus_rtu_request_framer_top test failed");
    $finish;
  end

  function automatic logic [15:0] modbus_crc_of(input logic [47:0] payload);
    logic [15:0] acc;
    logic        fb;
    acc = mbrtu_pkg::CRC_INIT;
    for (int b = 0; b < mbrtu_pkg::PAYLOAD_LEN; b++) begin
      for (int i = 0; i < mbrtu_pkg::BYTE_W; i++) begin
        fb  = acc[0] ^ payload[40 - 8 * b + i];
        acc = acc >> 1;
        if (fb) begin
          acc = acc ^ mbrtu_pkg::CRC_POLY;
        end
      end
    end
    return acc;
  endfunction

  task automatic queue_frame(input mbrtu_pkg::in_item_t req, input logic crc_given,
                             input logic [15:0] crc_typed);
    logic [15:0]          crc;
    logic [7:0]           frame_bytes [mbrtu_pkg::FRAME_LEN];
    mbrtu_pkg::out_item_t item;
    crc = crc_given ? crc_typed : modbus_crc_of(req);
    frame_bytes[0] = req.slave_addr;
    frame_bytes[1] = req.func_code;
    frame_bytes[2] = req.reg_addr[15:8];
    frame_bytes[3] = req.reg_addr[7:0];
    frame_bytes[4] = req.reg_value[15:8];
    frame_bytes[5] = req.reg_value[7:0];
    frame_bytes[6] = crc[7:0];
    frame_bytes[7] = crc[15:8];
    for (int k = 0; k < mbrtu_pkg::FRAME_LEN; k++) begin
      item.tx_byte   = frame_bytes[k];
      item.last_byte = (k == mbrtu_pkg::FRAME_LEN - 1);
      pending_bytes.push_back(item);
    end
  endtask

  task automatic send_request(input mbrtu_pkg::in_item_t req, input int unsigned gap,
                              input logic crc_given, input logic [15:0] crc_typed);
    repeat (gap) begin
      @(negedge clk);
      start   <= 1'b0;
      in_item <= mbrtu_pkg::in_item_t'(48'({$urandom, $urandom}));
    end
    @(negedge clk);
    start   <= 1'b1;
    in_item <= req;
    do @(posedge clk); while (busy);
    queue_frame(req, crc_given, crc_typed);
  endtask

  function automatic logic [7:0] biased_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] biased_word();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic mbrtu_pkg::in_item_t random_request();
    mbrtu_pkg::in_item_t req;
    req.slave_addr = biased_byte();
    case ($urandom_range(0, 3))
      0: req.func_code = FC_READ_HOLDING;
      1: req.func_code = FC_WRITE_SINGLE;
      default: req.func_code = biased_byte();
    endcase
    req.reg_addr  = biased_word();
    req.reg_value = biased_word();
    return req;
  endfunction

  always @(posedge clk) begin
    mbrtu_pkg::out_item_t want;
    if (rst_n && out_strobe) begin
      if (pending_bytes.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected byte, expected none, actual %h last %b",
                 $time, out_item.tx_byte, out_item.last_byte);
      end else begin
        want = pending_bytes.pop_front();
        if (out_item.tx_byte !== want.tx_byte) begin
          mismatches++;
          $display("%0t: tx_byte mismatch, expected %h, actual %h",
                   $time, want.tx_byte, out_item.tx_byte);
        end
        if (out_item.last_byte !== want.last_byte) begin
          mismatches++;
          $display("%0t: last_byte mismatch, expected %b, actual %b",
                   $time, want.last_byte, out_item.last_byte);
        end
      end
    end
  end

  initial begin
    bit burst;
    mismatches = 0;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_item    = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    foreach (REQUEST_TABLE[r]) begin
      send_request(REQUEST_TABLE[r].req, (r < 4) ? 0 : $urandom_range(0, 19),
                   REQUEST_TABLE[r].crc_given, REQUEST_TABLE[r].crc);
    end

    // hold off until the table's frames have all left
    @(negedge clk);
    start <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);

    burst = 1'b0;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 16 == 0) begin
        burst = ($urandom_range(0, 2) == 0);
      end
      send_request(random_request(), burst ? 0 : $urandom_range(0, 19), 1'b0, 16'h0000);
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("modbus_rtu_request_framer_top test passed");
    end else begin
      $display("modbus_rtu_request_framer_top test failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/mbrtu_pkg.sv
design/modbus_rtu_request_framer_top.sv
bench/modbus_rtu_request_framer_top_tb.sv
